### hw/rtl/lr_pkg.sv
// Line rasterizer shared package: command codes and fixed payload widths.
// No dependencies; imported by the channel interfaces and the top level.
package lr_pkg;

    localparam int unsigned COLOR_BITS = 32;

    typedef enum logic
    {
        CMD_LOAD = 1'b0,
        CMD_STEP = 1'b1
    } lr_cmd_t;

    typedef logic [COLOR_BITS-1:0] lr_color_t;

endpackage : lr_pkg

### hw/rtl/lr_if.sv
// Valid/ready channel interfaces for the line rasterizer: command in, pixel out.
// Depends on lr_pkg for the command code type and color width.
interface lr_cmd_if
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    lr_cmd_t               command;
    logic [COORD_BITS-1:0] x_start;
    logic [COORD_BITS-1:0] y_start;
    logic [COORD_BITS-1:0] x_end;
    logic [COORD_BITS-1:0] y_end;
    lr_color_t             color;

    modport source (output valid, command, x_start, y_start, x_end, y_end, color,
                    input ready);
    modport sink   (input valid, command, x_start, y_start, x_end, y_end, color,
                    output ready);
endinterface : lr_cmd_if

interface lr_pix_if
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;
    lr_color_t             pixel_color;
    logic                  last_pixel;

    modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    input ready);
    modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel,
                    output ready);
endinterface : lr_pix_if

### hw/rtl/line_rasterizer_top.sv
// Line rasterizer top: integer DDA stepping, one pixel per step on an active line.
// Latency: a step transfer shows its pixel on the output register the next cycle.
// Throughput: one command per cycle; the error add/compare closes in the accept cycle.
// The command side stalls only while the output register is full and not taken.
// Reset: asynchronous, active low; clears line state and leaves the block idle.
// Depends on lr_pkg and the lr_cmd_if / lr_pix_if interfaces.
module line_rasterizer_top
    import lr_pkg::*;
#(
    parameter int unsigned COORD_BITS = 12
)
(
    input  logic      clk,
    input  logic      rst_n,
    lr_cmd_if.sink    cmd,
    lr_pix_if.source  pix
);

    localparam int unsigned DW = COORD_BITS + 1;   // signed delta
    localparam int unsigned EW = COORD_BITS + 4;   // error accumulator
    localparam int unsigned TMIN_W = COORD_BITS + 2;
    localparam int unsigned TMAJ_W = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] coord_t;

    // line state
    coord_t                    cur_x_reg, cur_x_next;
    coord_t                    cur_y_reg, cur_y_next;
    coord_t                    major_end_reg, major_end_next;
    logic signed [EW-1:0]      err_acc_reg, err_acc_next;
    logic signed [TMIN_W-1:0]  tmin_reg, tmin_next;
    logic [TMAJ_W-1:0]         tmaj_reg, tmaj_next;
    logic                      x_major_reg, x_major_next;
    logic                      active_reg, active_next;
    lr_color_t                 color_reg, color_next;

    // output register
    logic                      out_valid_reg, out_valid_next;
    coord_t                    pix_x_reg, pix_x_next;
    coord_t                    pix_y_reg, pix_y_next;
    lr_color_t                 pix_color_reg, pix_color_next;
    logic                      pix_last_reg, pix_last_next;

    logic                      accept;
    logic                      emit;

    // load path
    logic signed [DW-1:0]      dx, dy, sdx, sdy, maj_d, min_d;
    coord_t                    adx, ady;
    logic                      ld_x_major, ld_swap;

    // step path
    logic signed [EW-1:0]      err_sum, half, tmaj_ext;
    logic                      step_up, step_dn;
    coord_t                    minor_next;
    logic                      last;

    assign cmd.ready = !out_valid_reg || pix.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign emit      = accept && (cmd.command == CMD_STEP) && active_reg;

    assign pix.valid       = out_valid_reg;
    assign pix.pixel_x     = pix_x_reg;
    assign pix.pixel_y     = pix_y_reg;
    assign pix.pixel_color = pix_color_reg;
    assign pix.last_pixel  = pix_last_reg;

    always_comb
    begin
        dx  = $signed({1'b0, cmd.x_end}) - $signed({1'b0, cmd.x_start});
        dy  = $signed({1'b0, cmd.y_end}) - $signed({1'b0, cmd.y_start});
        adx = dx[DW-1] ? coord_t'(-dx) : coord_t'(dx);
        ady = dy[DW-1] ? coord_t'(-dy) : coord_t'(dy);
        ld_x_major = adx > ady;
        ld_swap    = ld_x_major ? dx[DW-1] : dy[DW-1];
        sdx   = ld_swap ? -dx : dx;
        sdy   = ld_swap ? -dy : dy;
        maj_d = ld_x_major ? sdx : sdy;   // never negative
        min_d = ld_x_major ? sdy : sdx;
    end

    always_comb
    begin
        tmaj_ext = $signed({{(EW-TMAJ_W){1'b0}}, tmaj_reg});
        half     = $signed({{(EW-TMAJ_W+1){1'b0}}, tmaj_reg[TMAJ_W-1:1]});
        err_sum  = err_acc_reg + {{(EW-TMIN_W){tmin_reg[TMIN_W-1]}}, tmin_reg};
        step_up  = err_sum > half;
        step_dn  = !step_up && (err_sum < -half);
        minor_next = x_major_reg ? cur_y_reg : cur_x_reg;
        if (step_up)
        begin
            minor_next = minor_next + coord_t'(1);
        end
        else if (step_dn)
        begin
            minor_next = minor_next - coord_t'(1);
        end
        last = (x_major_reg ? cur_x_reg : cur_y_reg) == major_end_reg;
    end

    always_comb
    begin
        cur_x_next     = cur_x_reg;
        cur_y_next     = cur_y_reg;
        major_end_next = major_end_reg;
        err_acc_next   = err_acc_reg;
        tmin_next      = tmin_reg;
        tmaj_next      = tmaj_reg;
        x_major_next   = x_major_reg;
        active_next    = active_reg;
        color_next     = color_reg;

        out_valid_next = out_valid_reg && !pix.ready;
        pix_x_next     = pix_x_reg;
        pix_y_next     = pix_y_reg;
        pix_color_next = pix_color_reg;
        pix_last_next  = pix_last_reg;

        if (accept && (cmd.command == CMD_LOAD))
        begin
            cur_x_next     = ld_swap ? cmd.x_end : cmd.x_start;
            cur_y_next     = ld_swap ? cmd.y_end : cmd.y_start;
            major_end_next = ld_x_major ? (ld_swap ? cmd.x_start : cmd.x_end)
                                        : (ld_swap ? cmd.y_start : cmd.y_end);
            err_acc_next   = '0;
            tmaj_next      = {maj_d[COORD_BITS-1:0], 1'b0};
            tmin_next      = {min_d, 1'b0};
            x_major_next   = ld_x_major;
            active_next    = 1'b1;
            color_next     = cmd.color;
        end
        else if (emit)
        begin
            out_valid_next = 1'b1;
            pix_x_next     = cur_x_reg;
            pix_y_next     = cur_y_reg;
            pix_color_next = color_reg;
            pix_last_next  = last;
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                if (step_up)
                begin
                    err_acc_next = err_sum - tmaj_ext;
                end
                else if (step_dn)
                begin
                    err_acc_next = err_sum + tmaj_ext;
                end
                else
                begin
                    err_acc_next = err_sum;
                end
                if (x_major_reg)
                begin
                    cur_x_next = cur_x_reg + coord_t'(1);
                    cur_y_next = minor_next;
                end
                else
                begin
                    cur_y_next = cur_y_reg + coord_t'(1);
                    cur_x_next = minor_next;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            major_end_reg <= '0;
            err_acc_reg   <= '0;
            tmin_reg      <= '0;
            tmaj_reg      <= '0;
            x_major_reg   <= 1'b0;
            active_reg    <= 1'b0;
            color_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg     <= cur_x_next;
            cur_y_reg     <= cur_y_next;
            major_end_reg <= major_end_next;
            err_acc_reg   <= err_acc_next;
            tmin_reg      <= tmin_next;
            tmaj_reg      <= tmaj_next;
            x_major_reg   <= x_major_next;
            active_reg    <= active_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pix_x_reg     <= pix_x_next;
        pix_y_reg     <= pix_y_next;
        pix_color_reg <= pix_color_next;
        pix_last_reg  <= pix_last_next;
    end

endmodule : line_rasterizer_top
